/* hw/rtl/hcps_pkg.sv */
// shared types, constants and mod-26 helpers for the hill cipher pair stream
`default_nettype none

package hcps_pkg;

   // letter arithmetic
   localparam logic [4:0]  MOD_VAL     = 5'd26;
   localparam logic [10:0] MOD_SQ      = 11'd676;
   localparam logic [4:0]  PAD_LETTER  = 5'd23;
   localparam logic [7:0]  ASCII_UP_A  = 8'h41;
   localparam logic [7:0]  ASCII_UP_Z  = 8'h5a;
   localparam logic [7:0]  ASCII_LO_A  = 8'h61;
   localparam logic [7:0]  ASCII_LO_Z  = 8'h7a;

   // key reset values and fallback matrix
   localparam logic [4:0] KEY_A_RST = 5'd3;
   localparam logic [4:0] KEY_B_RST = 5'd3;
   localparam logic [4:0] KEY_C_RST = 5'd2;
   localparam logic [4:0] KEY_D_RST = 5'd5;
   localparam logic [4:0] FALLBACK_INV = 5'd3;

   // cycles from a key write until the derived matrix is valid
   localparam logic [1:0] SETTLE_CYCLES = 2'd3;

   typedef enum logic [2:0] {
      REG_KEY_A   = 3'd0,
      REG_KEY_B   = 3'd1,
      REG_KEY_C   = 3'd2,
      REG_KEY_D   = 3'd3,
      REG_DECRYPT = 3'd4
   } reg_idx_type;

   // active 2x2 matrix, entries 0..25
   typedef struct packed {
      logic [4:0] m0;
      logic [4:0] m1;
      logic [4:0] m2;
      logic [4:0] m3;
   } mat_type;

   // configuration block status towards the datapath
   typedef struct packed {
      mat_type mat;
      logic    busy;
   } cfg_type;

   // one result held in the output queue
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } res_type;

   // residue mod 26 of an 11-bit value, folding 32 = 6 (mod 26) twice
   function automatic logic [4:0] mod26(input logic [10:0] v);
      logic [8:0] s1;
      logic [6:0] s2;
      logic [6:0] r;
      s1 = {1'b0, v[10:5], 2'b00} + {2'b00, v[10:5], 1'b0} + {4'b0000, v[4:0]};
      s2 = 7'({3'b000, s1[8:5], 2'b00} + {4'b0000, s1[8:5], 1'b0}
              + {4'b0000, s1[4:0]});
      if (s2 >= 7'd78) begin
         r = s2 - 7'd78;
      end else if (s2 >= 7'd52) begin
         r = s2 - 7'd52;
      end else if (s2 >= 7'd26) begin
         r = s2 - 7'd26;
      end else begin
         r = s2;
      end
      return r[4:0];
   endfunction

   // reduce a 5-bit key entry to 0..25
   function automatic logic [4:0] reduce_key(input logic [4:0] k);
      return (k >= MOD_VAL) ? k - MOD_VAL : k;
   endfunction

   // additive inverse mod 26 of a value 0..25
   function automatic logic [4:0] neg26(input logic [4:0] k);
      return (k == 5'd0) ? 5'd0 : MOD_VAL - k;
   endfunction

   // multiplicative inverse mod 26, zero where none exists
   function automatic logic [4:0] det_inverse(input logic [4:0] det);
      logic [4:0] inv;
      unique case (det)
         5'd1:    inv = 5'd1;
         5'd3:    inv = 5'd9;
         5'd5:    inv = 5'd21;
         5'd7:    inv = 5'd15;
         5'd9:    inv = 5'd3;
         5'd11:   inv = 5'd19;
         5'd15:   inv = 5'd7;
         5'd17:   inv = 5'd23;
         5'd19:   inv = 5'd11;
         5'd21:   inv = 5'd5;
         5'd23:   inv = 5'd17;
         5'd25:   inv = 5'd25;
         default: inv = 5'd0;
      endcase
      return inv;
   endfunction

endpackage : hcps_pkg

`default_nettype wire

/* hw/rtl/hcps_csr.sv */
// register block and derived encrypt/decrypt matrix pipeline
`default_nettype none

module hcps_csr
   import hcps_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready,
   output cfg_type          cfg
);

   logic [4:0] key_a_ff, key_b_ff, key_c_ff, key_d_ff;
   logic       decrypt_ff;
   logic       wr_en;
   reg_idx_type wr_idx;

   // stage one: reduced keys and determinant products
   logic [4:0] ra_ff, rb_ff, rc_ff, rd_ff;
   logic [9:0] prod_ad_ff, prod_bc_ff;
   logic [4:0] ra_in, rb_in, rc_in, rd_in;

   // stage two: adjugate entries and determinant inverse
   logic [4:0] adj0_ff, adj1_ff, adj2_ff, adj3_ff, inv_ff;
   logic [4:0] ka2_ff, kb2_ff, kc2_ff, kd2_ff;
   logic [4:0] det_in, inv_raw;
   logic [4:0] fa, fb, fc, fd;

   // stage three: active matrix
   mat_type    mat_ff, mat_in;
   logic [1:0] settle_ff, settle_in;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign wr_idx     = reg_idx_type'(csr_paddr[4:2]);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         key_a_ff   <= KEY_A_RST;
         key_b_ff   <= KEY_B_RST;
         key_c_ff   <= KEY_C_RST;
         key_d_ff   <= KEY_D_RST;
         decrypt_ff <= 1'b0;
      end else if (wr_en) begin
         unique case (wr_idx)
            REG_KEY_A:   key_a_ff   <= csr_pwdata[4:0];
            REG_KEY_B:   key_b_ff   <= csr_pwdata[4:0];
            REG_KEY_C:   key_c_ff   <= csr_pwdata[4:0];
            REG_KEY_D:   key_d_ff   <= csr_pwdata[4:0];
            REG_DECRYPT: decrypt_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      csr_prdata = 32'd0;
      unique case (wr_idx)
         REG_KEY_A:   csr_prdata = {27'd0, key_a_ff};
         REG_KEY_B:   csr_prdata = {27'd0, key_b_ff};
         REG_KEY_C:   csr_prdata = {27'd0, key_c_ff};
         REG_KEY_D:   csr_prdata = {27'd0, key_d_ff};
         REG_DECRYPT: csr_prdata = {31'd0, decrypt_ff};
         default:     csr_prdata = 32'd0;
      endcase
   end

   // stage one
   assign ra_in = reduce_key(key_a_ff);
   assign rb_in = reduce_key(key_b_ff);
   assign rc_in = reduce_key(key_c_ff);
   assign rd_in = reduce_key(key_d_ff);

   always_ff @(posedge clock) begin
      ra_ff      <= ra_in;
      rb_ff      <= rb_in;
      rc_ff      <= rc_in;
      rd_ff      <= rd_in;
      prod_ad_ff <= {5'd0, ra_in} * {5'd0, rd_in};
      prod_bc_ff <= {5'd0, rb_in} * {5'd0, rc_in};
   end

   // stage two: determinant, inverse, fallback to the default matrix
   assign det_in  = mod26({1'b0, prod_ad_ff} + MOD_SQ - {1'b0, prod_bc_ff});
   assign inv_raw = det_inverse(det_in);

   always_comb begin
      if (inv_raw == 5'd0) begin
         fa = KEY_A_RST;
         fb = KEY_B_RST;
         fc = KEY_C_RST;
         fd = KEY_D_RST;
      end else begin
         fa = ra_ff;
         fb = rb_ff;
         fc = rc_ff;
         fd = rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      adj0_ff <= fd;
      adj1_ff <= neg26(fb);
      adj2_ff <= neg26(fc);
      adj3_ff <= fa;
      inv_ff  <= (inv_raw == 5'd0) ? FALLBACK_INV : inv_raw;
      ka2_ff  <= ra_ff;
      kb2_ff  <= rb_ff;
      kc2_ff  <= rc_ff;
      kd2_ff  <= rd_ff;
   end

   // stage three: scale the adjugate or take the key as it is
   always_comb begin
      if (decrypt_ff) begin
         mat_in.m0 = mod26({1'b0, {5'd0, adj0_ff} * {5'd0, inv_ff}});
         mat_in.m1 = mod26({1'b0, {5'd0, adj1_ff} * {5'd0, inv_ff}});
         mat_in.m2 = mod26({1'b0, {5'd0, adj2_ff} * {5'd0, inv_ff}});
         mat_in.m3 = mod26({1'b0, {5'd0, adj3_ff} * {5'd0, inv_ff}});
      end else begin
         mat_in.m0 = ka2_ff;
         mat_in.m1 = kb2_ff;
         mat_in.m2 = kc2_ff;
         mat_in.m3 = kd2_ff;
      end
   end

   always_ff @(posedge clock) begin
      mat_ff <= mat_in;
   end

   // hold off new items until the matrix pipeline has caught up
   assign settle_in = (settle_ff != 2'd0) ? settle_ff - 2'd1 : 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= SETTLE_CYCLES;
      end else if (wr_en) begin
         settle_ff <= SETTLE_CYCLES;
      end else begin
         settle_ff <= settle_in;
      end
   end

   assign cfg.mat  = mat_ff;
   assign cfg.busy = (settle_ff != 2'd0);

endmodule : hcps_csr

`default_nettype wire

/* hw/rtl/hcps_pair.sv */
// 2x2 matrix product mod 26 on one letter pair, result as upper-case ascii
`default_nettype none

module hcps_pair
   import hcps_pkg::*;
(
   input  mat_type          mat,
   input  wire logic [4:0]  x,
   input  wire logic [4:0]  y,
   output logic      [7:0]  rx_char,
   output logic      [7:0]  ry_char
);

   logic [9:0]  p0, p1, p2, p3;
   logic [10:0] sum_x, sum_y;
   logic [4:0]  rx, ry;

   // four narrow products in parallel
   assign p0 = {5'd0, mat.m0} * {5'd0, x};
   assign p1 = {5'd0, mat.m1} * {5'd0, y};
   assign p2 = {5'd0, mat.m2} * {5'd0, x};
   assign p3 = {5'd0, mat.m3} * {5'd0, y};

   // row sums and reduction
   assign sum_x = {1'b0, p0} + {1'b0, p1};
   assign sum_y = {1'b0, p2} + {1'b0, p3};
   assign rx    = mod26(sum_x);
   assign ry    = mod26(sum_y);

   assign rx_char = ASCII_UP_A + {3'd0, rx};
   assign ry_char = ASCII_UP_A + {3'd0, ry};

endmodule : hcps_pair

`default_nettype wire

/* hw/rtl/hcps_outq.sv */
// three-entry result queue that drains one transfer per cycle while rsp_tready is high
`default_nettype none

module hcps_outq
   import hcps_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        load,
   input  wire logic [1:0]  load_cnt,
   input  res_type          load_r0,
   input  res_type          load_r1,
   input  res_type          load_r2,
   output logic             can_load,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [7:0]  rsp_tdata,
   output logic             rsp_tlast
);

   res_type    ent0_ff, ent1_ff, ent2_ff;
   logic [1:0] cnt_ff;
   logic       pop;

   assign pop      = (cnt_ff != 2'd0) && rsp_tready;
   assign can_load = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_tready);

   // occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else if (load) begin
         cnt_ff <= load_cnt;
      end else if (pop) begin
         cnt_ff <= cnt_ff - 2'd1;
      end
   end

   // entries: load a fresh run or shift towards the head
   always_ff @(posedge clock) begin
      if (load) begin
         ent0_ff <= load_r0;
         ent1_ff <= load_r1;
         ent2_ff <= load_r2;
      end else if (pop) begin
         ent0_ff <= ent1_ff;
         ent1_ff <= ent2_ff;
      end
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = ent0_ff.data;
   assign rsp_tlast  = ent0_ff.last;

endmodule : hcps_outq

`default_nettype wire

/* hw/rtl/hill_cipher_pair_stream.sv */
// top level: 2x2 hill cipher mod 26 over a byte stream
//
//  channel   dir   handshake                 payload
//  req_*     in    tvalid / tready           tdata[7:0] in_byte
//  rsp_*     out   tvalid / tready           tdata[7:0] out_byte, tlast last_of_run
//  csr_*     in    psel / penable / pready   5 registers at 4*i, 32-bit data
//
// one byte is taken per cycle while each byte gives at most one result and the
// receiver is ready; a letter pair gives two transfers and a padded pair plus a
// passed byte three, drained by the one-transfer-per-cycle result queue. an input
// register sits in front of the queue so a byte is taken while a result waits.
// after reset and after any register write, req_tready stays low while the
// matrix pipeline settles. a letter still held at stream end is never sent.
`default_nettype none

module hill_cipher_pair_stream
   import hcps_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // input byte stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] in_byte
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic             rsp_tlast,   // last_of_run
   // register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   cfg_type    cfg;
   logic       in_vld_ff;
   logic [7:0] in_byte_ff;
   logic       pend_ff, pend_in;
   logic [4:0] held_ff, held_in;
   logic       can_load, step, req_xfer;
   logic       is_up, is_lo, is_letter;
   logic [4:0] letter;
   logic [4:0] pair_y;
   logic [7:0] rx_char, ry_char;
   logic       q_load;
   logic [1:0] q_cnt;
   res_type    q_r0, q_r1, q_r2;

   hcps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // input register
   assign step       = in_vld_ff && can_load;
   assign req_tready = !cfg.busy && (!in_vld_ff || can_load);
   assign req_xfer   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_xfer) begin
         in_vld_ff <= 1'b1;
      end else if (step) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req_tdata;
      end
   end

   // letter classification
   assign is_up     = (in_byte_ff >= ASCII_UP_A) && (in_byte_ff <= ASCII_UP_Z);
   assign is_lo     = (in_byte_ff >= ASCII_LO_A) && (in_byte_ff <= ASCII_LO_Z);
   assign is_letter = is_up || is_lo;
   assign letter    = is_up ? 5'(in_byte_ff - ASCII_UP_A) : 5'(in_byte_ff - ASCII_LO_A);

   // partner is the new letter, or the pad letter ahead of a non-letter
   assign pair_y = is_letter ? letter : PAD_LETTER;

   hcps_pair u_pair (
      .mat     (cfg.mat),
      .x       (held_ff),
      .y       (pair_y),
      .rx_char (rx_char),
      .ry_char (ry_char)
   );

   // results and held-letter update for the item in the input register
   always_comb begin
      pend_in = pend_ff;
      held_in = held_ff;
      q_cnt   = 2'd0;
      q_r0    = '{data: rx_char, last: 1'b0};
      q_r1    = '{data: ry_char, last: 1'b0};
      q_r2    = '{data: in_byte_ff, last: 1'b1};
      priority if (is_letter && !pend_ff) begin
         pend_in = 1'b1;
         held_in = letter;
      end else if (is_letter) begin
         pend_in = 1'b0;
         held_in = 5'd0;
         q_cnt   = 2'd2;
         q_r1    = '{data: ry_char, last: 1'b1};
      end else if (pend_ff) begin
         pend_in = 1'b0;
         held_in = 5'd0;
         q_cnt   = 2'd3;
      end else begin
         q_cnt   = 2'd1;
         q_r0    = '{data: in_byte_ff, last: 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         held_ff <= 5'd0;
      end else if (step) begin
         pend_ff <= pend_in;
         held_ff <= held_in;
      end
   end

   assign q_load = step;

   hcps_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .load       (q_load),
      .load_cnt   (q_cnt),
      .load_r0    (q_r0),
      .load_r1    (q_r1),
      .load_r2    (q_r2),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule : hill_cipher_pair_stream

`default_nettype wire

/* bench/hill_pair_checker.sv */
// checker for the hill cipher pair stream: predicts every result transfer and compares it
`timescale 1ns / 1ps

module hill_pair_checker
   import hcps_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] in_byte
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [7:0]  rsp_tdata,   // [7:0] out_byte
   input  wire logic        rsp_tlast,   // last_of_run
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   input  wire logic        csr_pready,
   output int               fail_count,
   output int               open_count
);

   // shadow of the key registers and of the pairing state
   logic [4:0] key_a, key_b, key_c, key_d;
   logic       decrypt_on;
   logic       letter_held;
   logic [4:0] held_value;

   // cipher letters and passed bytes still to arrive, oldest first
   res_type    cipher_q[$];
   int         errors;

   // matrix in use for the current key and direction
   function automatic mat_type working_matrix();
      int      ka, kb, kc, kd, det, inv, i;
      mat_type m;
      ka = int'(key_a) % 26;
      kb = int'(key_b) % 26;
      kc = int'(key_c) % 26;
      kd = int'(key_d) % 26;
      if (decrypt_on) begin
         det = (ka * kd - kb * kc) % 26;
         if (det < 0) det = det + 26;
         inv = 0;
         for (i = 1; i < 26; i++) begin
            if ((det * i) % 26 == 1) inv = i;
         end
         // singular key: fall back to the reset matrix and its inverse
         if (inv == 0) begin
            ka  = int'(KEY_A_RST);
            kb  = int'(KEY_B_RST);
            kc  = int'(KEY_C_RST);
            kd  = int'(KEY_D_RST);
            inv = int'(FALLBACK_INV);
         end
         m.m0 = 5'((kd * inv) % 26);
         m.m1 = 5'((((26 - kb) % 26) * inv) % 26);
         m.m2 = 5'((((26 - kc) % 26) * inv) % 26);
         m.m3 = 5'((ka * inv) % 26);
      end else begin
         m.m0 = 5'(ka);
         m.m1 = 5'(kb);
         m.m2 = 5'(kc);
         m.m3 = 5'(kd);
      end
      return m;
   endfunction

   // append one expected result at the tail
   task automatic add_expected(input res_type r);
      cipher_q.insert(cipher_q.size(), r);
   endtask

   // transform one letter pair and queue the two cipher letters
   task automatic push_pair(input logic [4:0] x, input logic [4:0] y, input logic last_flag);
      mat_type m;
      int      rx, ry;
      res_type r;
      m  = working_matrix();
      rx = (int'(m.m0) * int'(x) + int'(m.m1) * int'(y)) % 26;
      ry = (int'(m.m2) * int'(x) + int'(m.m3) * int'(y)) % 26;
      r.data = 8'(rx) + ASCII_UP_A;
      r.last = 1'b0;
      add_expected(r);
      r.data = 8'(ry) + ASCII_UP_A;
      r.last = last_flag;
      add_expected(r);
   endtask

   // predict the results of one accepted input byte
   task automatic cipher_byte_in(input logic [7:0] b);
      logic       is_up, is_lo;
      logic [4:0] v;
      res_type    r;
      is_up = (b >= ASCII_UP_A) && (b <= ASCII_UP_Z);
      is_lo = (b >= ASCII_LO_A) && (b <= ASCII_LO_Z);
      if (is_up || is_lo) begin
         v = is_up ? 5'(b - ASCII_UP_A) : 5'(b - ASCII_LO_A);
         if (!letter_held) begin
            letter_held = 1'b1;
            held_value  = v;
         end else begin
            push_pair(held_value, v, 1'b1);
            letter_held = 1'b0;
            held_value  = 5'd0;
         end
      end else begin
         // a held letter is padded and its pair goes ahead of the byte
         if (letter_held) begin
            push_pair(held_value, PAD_LETTER, 1'b0);
            letter_held = 1'b0;
            held_value  = 5'd0;
         end
         r.data = b;
         r.last = 1'b1;
         add_expected(r);
      end
   endtask

   // watch register writes, input and result transfers
   always @(posedge clock) begin
      res_type want;
      if (reset) begin
         key_a       = KEY_A_RST;
         key_b       = KEY_B_RST;
         key_c       = KEY_C_RST;
         key_d       = KEY_D_RST;
         decrypt_on  = 1'b0;
         letter_held = 1'b0;
         held_value  = 5'd0;
         cipher_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               REG_KEY_A:   key_a = csr_pwdata[4:0];
               REG_KEY_B:   key_b = csr_pwdata[4:0];
               REG_KEY_C:   key_c = csr_pwdata[4:0];
               REG_KEY_D:   key_d = csr_pwdata[4:0];
               REG_DECRYPT: decrypt_on = csr_pwdata[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            cipher_byte_in(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (cipher_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result transfer, expected none, got %02h last %0b",
                        $time, rsp_tdata, rsp_tlast);
            end else begin
               want = cipher_q.pop_front();
               if (rsp_tdata !== want.data || rsp_tlast !== want.last) begin
                  errors++;
                  $display("%0t: result mismatch, expected %02h last %0b, got %02h last %0b",
                           $time, want.data, want.last, rsp_tdata, rsp_tlast);
               end
            end
         end
      end
      fail_count <= errors;
      open_count <= cipher_q.size();
   end

endmodule

/* bench/tb_hill_cipher_pair_stream.sv */
// testbench top for the hill cipher pair stream: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_hill_cipher_pair_stream
   import hcps_pkg::*;
();

   localparam logic [4:0] SPARE_ADDR = 5'd20;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;     // [7:0] in_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;     // [7:0] out_byte
   logic        rsp_tlast;     // last_of_run
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          fail_count;
   int          open_count;

   // sender burst state
   int          burst_left;
   bit          gaps_on;
   bit          valid_up;

   // receiver stall pattern state
   int          stall_left = 0;
   int          stall_mode = 0;

   hill_cipher_pair_stream DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   hill_pair_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .open_count  (open_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // overall time limit
   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   // receiver back-pressure, switching at random between four patterns
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(16, 80);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 3) != 0);
         2:       rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= ~rsp_tready;
      endcase
   end

   // one byte transfer, then a random gap when the burst runs out and gaps are on
   task automatic send_byte(input logic [7:0] b);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      valid_up = 1'b1;
      do @(posedge clock); while (!req_tready);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (gaps_on) begin
            req_tvalid <= 1'b0;
            valid_up = 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) begin
         send_byte(s[i]);
      end
   endtask

   // mostly letters in random case, the rest any non-letter byte
   function automatic logic [7:0] random_text_byte();
      logic [7:0] b;
      if ($urandom_range(0, 99) < 70) begin
         b = 8'($urandom_range(0, 25));
         b = b + (($urandom_range(0, 1) != 0) ? ASCII_UP_A : ASCII_LO_A);
      end else begin
         do begin
            b = 8'($urandom_range(0, 255));
         end while ((b >= ASCII_UP_A && b <= ASCII_UP_Z) || (b >= ASCII_LO_A && b <= ASCII_LO_Z));
      end
      return b;
   endfunction

   task automatic send_random(input int count);
      int i;
      gaps_on = ($urandom_range(0, 3) != 0);
      for (i = 0; i < count; i++) begin
         send_byte(random_text_byte());
      end
   endtask

   // stop sending and let every expected result drain
   task automatic quiesce();
      if (valid_up) begin
         req_tvalid <= 1'b0;
         valid_up = 1'b0;
      end
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // register write: setup cycle, then access until pready
   task automatic csr_write(input logic [4:0] addr, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // write the whole key and direction, with random noise in the unused bits
   task automatic set_keys(input logic [4:0] ka, input logic [4:0] kb, input logic [4:0] kc,
                           input logic [4:0] kd, input logic mode);
      csr_write({REG_KEY_A, 2'b00}, ($urandom() & 32'hffff_ffe0) | 32'(ka));
      csr_write({REG_KEY_B, 2'b00}, ($urandom() & 32'hffff_ffe0) | 32'(kb));
      csr_write({REG_KEY_C, 2'b00}, ($urandom() & 32'hffff_ffe0) | 32'(kc));
      csr_write({REG_KEY_D, 2'b00}, ($urandom() & 32'hffff_ffe0) | 32'(kd));
      csr_write({REG_DECRYPT, 2'b00}, ($urandom() & 32'hffff_fffe) | 32'(mode));
   endtask

   // stimulus
   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= 8'h00;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= 5'd0;
      csr_pwdata  <= 32'd0;
      valid_up   = 1'b0;
      gaps_on    = 1'b1;
      burst_left = $urandom_range(1, 16);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset key, encrypt: case and range edges, padding before a non-letter
      send_text("AZazAz");
      send_text("q");
      send_byte(8'h00);
      send_byte(8'hff);
      send_text("m");
      send_byte(8'h80);
      send_text("@[`{");
      send_text("Z");
      send_byte("{");
      send_text("ab");
      send_random(30);

      // key values above 25 are reduced, writes beyond the register list are ignored
      quiesce();
      set_keys(5'd31, 5'd30, 5'd29, 5'd28, 1'b0);
      csr_write(SPARE_ADDR, '1);
      send_random(40);

      // decrypt with the reset key
      quiesce();
      set_keys(KEY_A_RST, KEY_B_RST, KEY_C_RST, KEY_D_RST, 1'b1);
      send_text("AZaz");
      send_random(40);

      // singular key: fallback in decrypt, used as given in encrypt
      quiesce();
      set_keys(5'd0, 5'd0, 5'd0, 5'd0, 1'b1);
      send_random(35);
      quiesce();
      set_keys(5'd0, 5'd0, 5'd0, 5'd0, 1'b0);
      send_random(25);
      quiesce();
      set_keys(5'd25, 5'd25, 5'd25, 5'd25, 1'b0);
      send_random(30);
      quiesce();
      set_keys(5'd25, 5'd25, 5'd25, 5'd25, 1'b1);
      send_random(30);

      // invertible key other than the reset one
      quiesce();
      set_keys(5'd5, 5'd17, 5'd8, 5'd3, 1'b1);
      send_random(25);

      // random keys and directions
      repeat (4) begin
         quiesce();
         set_keys(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                  5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                  1'($urandom_range(0, 1)));
         send_random(30);
      end

      // a letter left alone at stream end is dropped
      quiesce();
      send_text("k");

      quiesce();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && open_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
